// ===== hdl/pcf_pkg.sv =====
// Shared types and constants for the presence change filter cache.
// No dependencies; imported by every module of the block.
package pcf_pkg;

  localparam int ADDR_W        = 16;
  localparam int PRES_W        = 2;
  localparam int CACHE_ENTRIES = 8;
  localparam int ENTRY_IDX_W   = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;

  localparam logic [ADDR_W-1:0] UNICAST_MAX = 16'h7FFF;

  typedef enum logic [1:0] {
    KIND_NONE    = 2'd0,
    KIND_SELF    = 2'd1,
    KIND_DIRECT  = 2'd2,
    KIND_CHANGED = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ROUTE_NONE   = 2'd0,
    ROUTE_SELF   = 2'd1,
    ROUTE_DIRECT = 2'd2,
    ROUTE_CACHE  = 2'd3
  } route_t;

  typedef struct packed {
    logic              valid;
    logic [ADDR_W-1:0] addr;
    logic [PRES_W-1:0] pres;
  } cache_req_t;

endpackage

// ===== hdl/pcf_classify.sv =====
// Report classifier: decides whether a report is local, direct, dropped
// or goes to the cache. Pure combinational; depends on pcf_pkg.
module pcf_classify (
  input  logic [pcf_pkg::ADDR_W-1:0] local_address,
  input  logic [pcf_pkg::ADDR_W-1:0] source_address,
  input  logic [pcf_pkg::ADDR_W-1:0] dest_address,
  output pcf_pkg::route_t            route
);
  import pcf_pkg::*;

  logic dst_unicast;

  assign dst_unicast = (dest_address != '0) && (dest_address <= UNICAST_MAX);

  always_comb begin
    if (source_address == local_address) begin
      route = dst_unicast ? ROUTE_SELF : ROUTE_NONE;
    end else if (dst_unicast) begin
      route = ROUTE_DIRECT;
    end else if (source_address == '0) begin
      // address zero marks an empty slot and cannot be cached
      route = ROUTE_NONE;
    end else begin
      route = ROUTE_CACHE;
    end
  end

endmodule

// ===== hdl/pcf_cache.sv =====
// Fully associative presence cache with first-empty fill and round-robin
// replacement. Lookup is combinational, update at the clock; uses pcf_pkg.
module pcf_cache (
  input  logic                clk,
  input  logic                rst_n,
  input  pcf_pkg::cache_req_t req,
  output logic                changed
);
  import pcf_pkg::*;

  logic [ADDR_W-1:0]      entry_address_r  [CACHE_ENTRIES];
  logic [PRES_W-1:0]      entry_presence_r [CACHE_ENTRIES];
  logic [ENTRY_IDX_W-1:0] victim_head_r;
  logic [ENTRY_IDX_W-1:0] victim_head_nxt;

  logic [CACHE_ENTRIES-1:0] hit_vec;
  logic [CACHE_ENTRIES-1:0] empty_vec;
  logic [ENTRY_IDX_W-1:0]   hit_idx;
  logic [ENTRY_IDX_W-1:0]   empty_idx;
  logic [ENTRY_IDX_W-1:0]   fill_idx;
  logic                     hit;
  logic                     any_empty;
  logic                     same_pres;

  always_comb begin
    for (int i = 0; i < CACHE_ENTRIES; i++) begin
      hit_vec[i]   = (entry_address_r[i] == req.addr);
      empty_vec[i] = (entry_address_r[i] == '0);
    end
  end

  // lowest set bit wins; scan from the top so the lowest overrides
  always_comb begin
    hit_idx   = '0;
    empty_idx = '0;
    for (int i = CACHE_ENTRIES - 1; i >= 0; i--) begin
      if (hit_vec[i]) begin
        hit_idx = ENTRY_IDX_W'(i);
      end
      if (empty_vec[i]) begin
        empty_idx = ENTRY_IDX_W'(i);
      end
    end
  end

  assign hit       = |hit_vec;
  assign any_empty = |empty_vec;
  assign same_pres = (entry_presence_r[hit_idx] == req.pres);
  assign changed   = req.valid && !(hit && same_pres);
  assign fill_idx  = any_empty ? empty_idx : victim_head_r;

  always_comb begin
    victim_head_nxt = victim_head_r;
    if (req.valid && !hit && !any_empty) begin
      if (victim_head_r == ENTRY_IDX_W'(CACHE_ENTRIES - 1)) begin
        victim_head_nxt = '0;
      end else begin
        victim_head_nxt = victim_head_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      victim_head_r <= '0;
      for (int i = 0; i < CACHE_ENTRIES; i++) begin
        entry_address_r[i]  <= '0;
        entry_presence_r[i] <= '0;
      end
    end else begin
      victim_head_r <= victim_head_nxt;
      if (req.valid) begin
        if (hit) begin
          entry_presence_r[hit_idx] <= req.pres;
        end else begin
          entry_address_r[fill_idx]  <= req.addr;
          entry_presence_r[fill_idx] <= req.pres;
        end
      end
    end
  end

endmodule

// ===== hdl/presence_change_filter_cache.sv =====
// Top level of the presence change filter cache.
// Instantiates pcf_classify and pcf_cache; uses pcf_pkg.
//
// Usage:
//   Input channel: drive in_source_address, in_dest_address and in_presence
//   with start high; the report transfers at a clock edge where start is
//   high and busy is low. busy stays low, so a report may transfer every
//   cycle.
//   Result channel: each report gives exactly one result. out_valid is high
//   for one cycle with out_report_kind, out_reported_address and
//   out_reported_presence; the result transfers at the edge ending that
//   cycle. The receiver cannot stall.
//   The result passes through the input register, then the result register,
//   before it transfers. Throughput: 1 report per cycle; the cache lookup,
//   fill pick and update all settle between those registers, so
//   back-to-back reports see each other's updates.
//   Configuration: cfg_we writes cfg_wdata into local_address; write only
//   while no report is in flight.
//   Reset (rst_n low, synchronous): local_address 0, all cache slots empty,
//   replacement head 0, no result pending.
module presence_change_filter_cache (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic [pcf_pkg::ADDR_W-1:0] in_source_address,
  input  logic [pcf_pkg::ADDR_W-1:0] in_dest_address,
  input  logic [pcf_pkg::PRES_W-1:0] in_presence,
  output logic                       out_valid,
  output logic [1:0]                 out_report_kind,
  output logic [pcf_pkg::ADDR_W-1:0] out_reported_address,
  output logic [pcf_pkg::PRES_W-1:0] out_reported_presence,
  input  logic                       cfg_we,
  input  logic [pcf_pkg::ADDR_W-1:0] cfg_wdata
);
  import pcf_pkg::*;

  logic [ADDR_W-1:0] local_address_r;

  logic              in_valid_r;
  logic [ADDR_W-1:0] src_r;
  logic [ADDR_W-1:0] dst_r;
  logic [PRES_W-1:0] pres_r;

  route_t     route;
  cache_req_t cache_req;
  logic       cache_changed;
  kind_t      kind_nxt;

  logic              out_valid_r;
  kind_t             kind_r;
  logic [ADDR_W-1:0] addr_r;
  logic [PRES_W-1:0] pres_out_r;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      local_address_r <= '0;
    end else if (cfg_we) begin
      local_address_r <= cfg_wdata;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      src_r  <= in_source_address;
      dst_r  <= in_dest_address;
      pres_r <= in_presence;
    end
  end

  pcf_classify u_classify (
    .local_address  (local_address_r),
    .source_address (src_r),
    .dest_address   (dst_r),
    .route          (route)
  );

  assign cache_req.valid = in_valid_r && (route == ROUTE_CACHE);
  assign cache_req.addr  = src_r;
  assign cache_req.pres  = pres_r;

  pcf_cache u_cache (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (cache_req),
    .changed (cache_changed)
  );

  always_comb begin
    case (route)
      ROUTE_SELF:   kind_nxt = KIND_SELF;
      ROUTE_DIRECT: kind_nxt = KIND_DIRECT;
      ROUTE_CACHE:  kind_nxt = cache_changed ? KIND_CHANGED : KIND_NONE;
      default:      kind_nxt = KIND_NONE;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid_r) begin
      kind_r     <= kind_nxt;
      addr_r     <= src_r;
      pres_out_r <= pres_r;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_report_kind       = kind_r;
  assign out_reported_address  = addr_r;
  assign out_reported_presence = pres_out_r;

endmodule

// ===== hdl/pcf_checker.sv =====
// Port-level checks for the presence change filter cache, bound to the top.
// Depends on pcf_pkg and presence_change_filter_cache.
module pcf_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       start,
  input logic                       busy,
  input logic [pcf_pkg::ADDR_W-1:0] in_source_address,
  input logic [pcf_pkg::PRES_W-1:0] in_presence,
  input logic                       out_valid,
  input logic [pcf_pkg::ADDR_W-1:0] out_reported_address,
  input logic [pcf_pkg::PRES_W-1:0] out_reported_presence
);
  import pcf_pkg::*;

  // every transfer produces a result after the input and result registers
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> ##1 out_valid)
    else $error("transfer did not produce a result");

  // no result without a matching earlier transfer
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, 2))
    else $error("result without a matching transfer");

  // echoed fields match the transferred report
  a_echo: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_reported_address == $past(in_source_address, 2)) &&
                  (out_reported_presence == $past(in_presence, 2)))
    else $error("echoed fields do not match the report");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result strobe after reset");

endmodule

bind presence_change_filter_cache pcf_checker u_pcf_checker (.*);

// ===== dv/presence_change_filter_cache_test.sv =====
// Self-checking testbench for presence_change_filter_cache: directed and random presence reports
// checked against an in-bench predictor of the classification and replacement cache.
// Depends on pcf_pkg and the presence_change_filter_cache RTL only.
module presence_change_filter_cache_test;
  import pcf_pkg::*;

  localparam int RUN_LIMIT     = 400000;
  localparam int SEGMENT_ITEMS = 292;
  localparam int POOL_MAX      = 16;

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [PRES_W-1:0] pres_t;

  typedef struct {
    kind_t kind;
    addr_t addr;
    pres_t pres;
  } presence_result_t;

  class presence_scoreboard;
    bit [ADDR_W-1:0]  local_addr;
    bit [ADDR_W-1:0]  slot_addr[CACHE_ENTRIES];
    bit [PRES_W-1:0]  slot_pres[CACHE_ENTRIES];
    int unsigned      victim;
    presence_result_t expected_q[$];
    int unsigned      error_count;
    int unsigned      result_count;
    int unsigned      replace_count;
    int unsigned      kind_count[4];

    function kind_t predict_kind(addr_t src, addr_t dst, pres_t pres);
      bit unicast;
      int hit;
      int slot;
      unicast = (dst != '0) && (dst <= UNICAST_MAX);
      if (src == local_addr) return unicast ? KIND_SELF : KIND_NONE;
      if (unicast) return KIND_DIRECT;
      // address 0 marks an empty slot, so it can never be cached
      if (src == '0) return KIND_NONE;
      hit = -1;
      for (int i = 0; i < CACHE_ENTRIES; i++)
        if (hit < 0 && slot_addr[i] == src) hit = i;
      if (hit >= 0) begin
        if (slot_pres[hit] == pres) return KIND_NONE;
        slot_pres[hit] = pres;
        return KIND_CHANGED;
      end
      slot = -1;
      for (int i = 0; i < CACHE_ENTRIES; i++)
        if (slot < 0 && slot_addr[i] == '0) slot = i;
      if (slot < 0) begin
        slot = victim;
        victim = (victim + 1) % CACHE_ENTRIES;
        replace_count++;
      end
      slot_addr[slot] = src;
      slot_pres[slot] = pres;
      return KIND_CHANGED;
    endfunction

    function void note_report(addr_t src, addr_t dst, pres_t pres);
      presence_result_t r;
      r.kind = predict_kind(src, dst, pres);
      r.addr = src;
      r.pres = pres;
      expected_q.push_back(r);
    endfunction

    task mismatch(string msg);
      error_count++;
      $display("MISMATCH at %0t: %s", $time, msg);
    endtask

    task check_result(logic [1:0] kind, addr_t addr, pres_t pres);
      presence_result_t e;
      result_count++;
      if (expected_q.size() == 0) begin
        mismatch($sformatf("unexpected result kind %0d addr %h pres %0d", kind, addr, pres));
        return;
      end
      e = expected_q.pop_front();
      kind_count[e.kind]++;
      if (kind !== e.kind)
        mismatch($sformatf("kind %0d, want %s (addr %h)", kind, e.kind.name(), e.addr));
      if (addr !== e.addr)
        mismatch($sformatf("reported address %h, want %h", addr, e.addr));
      if (pres !== e.pres)
        mismatch($sformatf("reported presence %0d, want %0d (addr %h)", pres, e.pres, e.addr));
    endtask
  endclass

  logic  clk;
  logic  rst_n;
  logic  start;
  logic  busy;
  addr_t in_source_address;
  addr_t in_dest_address;
  pres_t in_presence;
  logic  out_valid;
  logic [1:0] out_report_kind;
  addr_t out_reported_address;
  pres_t out_reported_presence;
  logic  cfg_we;
  addr_t cfg_wdata;

  presence_scoreboard sb = new;
  addr_t       src_pool[POOL_MAX];
  int unsigned pool_size;

  presence_change_filter_cache dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .start                 (start),
    .busy                  (busy),
    .in_source_address     (in_source_address),
    .in_dest_address       (in_dest_address),
    .in_presence           (in_presence),
    .out_valid             (out_valid),
    .out_report_kind       (out_report_kind),
    .out_reported_address  (out_reported_address),
    .out_reported_presence (out_reported_presence),
    .cfg_we                (cfg_we),
    .cfg_wdata             (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #(RUN_LIMIT);
    $display("CHECKS FAILED");
    $finish;
  end

  // Watch every edge: results, register writes and report transfers.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid)
        sb.check_result(out_report_kind, out_reported_address, out_reported_presence);
      if (cfg_we) sb.local_addr = cfg_wdata;
      if (start && !busy) sb.note_report(in_source_address, in_dest_address, in_presence);
    end
  end

  task automatic send_report(addr_t src, addr_t dst, pres_t pres);
    in_source_address <= src;
    in_dest_address   <= dst;
    in_presence       <= pres;
    start             <= 1'b1;
    do @(posedge clk); while (busy);
  endtask

  task automatic pause(int unsigned cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (sb.expected_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_local(addr_t value);
    drain();
    repeat (2) @(posedge clk);
    cfg_wdata <= value;
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Small address pools make hits, presence changes and replacements common.
  task automatic refresh_pool();
    pool_size = $urandom_range(4, POOL_MAX);
    for (int i = 0; i < POOL_MAX; i++)
      src_pool[i] = addr_t'($urandom_range(1, 16'hFFFF));
  endtask

  function automatic addr_t pick_source();
    case ($urandom_range(0, 19))
      0:       return '0;
      1:       return sb.local_addr;
      2, 3:    return addr_t'($urandom_range(0, 16'hFFFF));
      default: return src_pool[$urandom_range(0, pool_size - 1)];
    endcase
  endfunction

  function automatic addr_t pick_dest();
    case ($urandom_range(0, 19))
      0:                 return '0;
      1:                 return 16'h0001;
      2:                 return UNICAST_MAX;
      3:                 return 16'h8000;
      4:                 return 16'hFFFF;
      5, 6, 7, 8, 9, 10: return addr_t'($urandom_range(16'h8000, 16'hFFFF));
      default:           return addr_t'($urandom_range(1, UNICAST_MAX));
    endcase
  endfunction

  initial begin
    addr_t       settings[6];
    addr_t       fill_addr[7];
    int unsigned idle_pct;
    settings  = '{16'hFFFF, 16'h0001, 16'h7FFF, 16'h8000, 16'h0000, 16'h0000};
    fill_addr = '{16'h8000, 16'hFFFF, 16'h5555, 16'hAAAA, 16'h00FF, 16'hFF00, 16'h7FFF};
    settings[2] = addr_t'($urandom_range(1, 16'hFFFF));
    rst_n             = 1'b0;
    start             = 1'b0;
    cfg_we            = 1'b0;
    cfg_wdata         = '0;
    in_source_address = '0;
    in_dest_address   = '0;
    in_presence       = '0;
    pool_size         = 1;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // local address still 0 from reset: source 0 counts as local
    send_report(16'h0000, 16'h0001, 2'd0);
    send_report(16'h0000, 16'h0000, 2'd1);
    send_report(16'h0000, 16'h8000, 2'd2);
    send_report(16'hFFFF, UNICAST_MAX, 2'd3);
    send_report(16'h0001, 16'h0000, 2'd1);
    send_report(16'h0001, 16'hFFFF, 2'd1);
    pause(3);
    send_report(16'h0001, 16'h8000, 2'd2);
    // fill the cache, then force two replacements and re-add an evicted address
    for (int i = 0; i < 7; i++)
      send_report(fill_addr[i], 16'hFFFF, pres_t'(i));
    send_report(16'h1234, 16'hC000, 2'd3);
    send_report(16'h0001, 16'h8001, 2'd0);
    write_local(16'hFFFF);
    send_report(16'hFFFF, UNICAST_MAX, 2'd2);
    send_report(16'hFFFF, 16'h8000, 2'd0);
    send_report(16'h0000, 16'hFFFF, 2'd3);

    for (int seg = 0; seg < 6; seg++) begin
      idle_pct = (seg < 2) ? 23 : (seg < 4) ? 75 : 0;
      write_local(settings[seg]);
      for (int n = 0; n < SEGMENT_ITEMS; n++) begin
        if (n % 40 == 0) refresh_pool();
        // idle each cycle with the segment's probability
        while ($urandom_range(0, 99) < idle_pct) pause(1);
        send_report(pick_source(), pick_dest(), pres_t'($urandom_range(0, 3)));
      end
    end

    drain();
    repeat (4) @(posedge clk);
    $display("Checked %0d results: none %0d, self %0d, direct %0d, changed %0d",
             sb.result_count, sb.kind_count[KIND_NONE], sb.kind_count[KIND_SELF],
             sb.kind_count[KIND_DIRECT], sb.kind_count[KIND_CHANGED]);
    $display("%0d cache replacements over 7 local-address settings, sender gaps 23%%/75%%/none",
             sb.replace_count);
    if (sb.error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/pcf_pkg.sv
hdl/pcf_classify.sv
hdl/pcf_cache.sv
hdl/presence_change_filter_cache.sv
hdl/pcf_checker.sv
dv/presence_change_filter_cache_test.sv
